// File: rtl/bounded_list_store_core_defines.svh
// Assertion macros used by the bounded list store top level.
`ifndef BOUNDED_LIST_STORE_CORE_DEFINES_SVH
`define BOUNDED_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BLS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bls_pkg.sv
// Types, codes and constants of the bounded list store.
`default_nettype none

package bls_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT       = 2'd0,
        ACT_FIND         = 2'd1,
        ACT_REMOVE_FRONT = 2'd2,
        ACT_REMOVE_MATCH = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    cnt_dec;
        logic    scan_start;
        logic    scan_step;
        logic    shift_start;
        logic    shift_step;
        logic    res_load;
        status_t res_status;
        logic    res_found;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t action;
        logic    empty;
        logic    full;
        logic    hit;
        logic    scan_end;
        logic    shift_end;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/bls_datapath.sv
// Datapath of the bounded list store: entry memory, count, scan and shift pointers.
`default_nettype none

module bls_datapath #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire bls_pkg::action_t                s_action,
    input  wire logic [bls_pkg::VALUE_W-1:0]     s_value,
    input  wire bls_pkg::cmd_t                   cmd,
    output bls_pkg::stat_t                       stat,
    output bls_pkg::status_t                     res_status,
    output logic                                 res_found,
    output logic [bls_pkg::COUNT_W-1:0]          res_count
);
    import bls_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Entries are held oldest first: the front of the list is address count-1
    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic [VALUE_W-1:0] value_reg;
    action_t            action_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      ptr_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               rd_valid_reg;
    status_t            status_reg;
    logic               found_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               ptr_nz;
    logic               ptr_lt;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    // Memory port selection
    always_comb begin
        ptr_nz  = (ptr_reg != '0);
        ptr_lt  = (ptr_reg < count_reg);
        rd_en   = (cmd.scan_step && ptr_nz) || (cmd.shift_step && ptr_lt);
        rd_addr = cmd.scan_step ? AW'(ptr_reg - CW'(1)) : AW'(ptr_reg);
        wr_en   = cmd.insert || (cmd.shift_step && rd_valid_reg);
        wr_addr = cmd.insert ? AW'(count_reg) : (rd_addr_reg - AW'(1));
        wr_data = cmd.insert ? value_reg : rdata_reg;
    end

    // Status flags for the controller
    always_comb begin
        stat.action    = action_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == DEPTH_C);
        stat.hit       = rd_valid_reg && (rdata_reg == value_reg);
        stat.scan_end  = !ptr_nz && !rd_valid_reg;
        stat.shift_end = !ptr_lt && !rd_valid_reg;
    end

    // Count and pointer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.insert) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end

            priority if (cmd.scan_start) begin
                ptr_reg      <= count_reg;
                rd_valid_reg <= 1'b0;
            end else if (cmd.shift_start) begin
                ptr_reg      <= CW'(rd_addr_reg) + CW'(1);
                rd_valid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                ptr_reg      <= ptr_nz ? (ptr_reg - CW'(1)) : ptr_reg;
                rd_valid_reg <= ptr_nz;
            end else if (cmd.shift_step) begin
                ptr_reg      <= ptr_lt ? (ptr_reg + CW'(1)) : ptr_reg;
                rd_valid_reg <= ptr_lt;
            end else begin
                ptr_reg      <= ptr_reg;
                rd_valid_reg <= rd_valid_reg;
            end
        end
    end

    // Capture the transaction, access the memory, hold the result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            value_reg  <= s_value;
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.res_load) begin
            status_reg    <= cmd.res_status;
            found_reg     <= cmd.res_found;
            count_out_reg <= COUNT_W'(count_reg);
        end
    end

    assign res_status = status_reg;
    assign res_found  = found_reg;
    assign res_count  = count_out_reg;

endmodule

`default_nettype wire

// File: rtl/bls_ctrl.sv
// Controller state machine of the bounded list store.
`default_nettype none

module bls_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire bls_pkg::stat_t  stat,
    output bls_pkg::cmd_t        cmd
);
    import bls_pkg::*;

    state_t  state_reg,        state_next;
    status_t pend_status_reg,  pend_status_next;
    logic    pend_found_reg,   pend_found_next;
    logic    out_valid_reg,    out_valid_next;
    logic    slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (stat.action)
                    ACT_INSERT, ACT_REMOVE_FRONT: state_next = S_FINISH;
                    ACT_FIND, ACT_REMOVE_MATCH: begin
                        state_next = stat.empty ? S_FINISH : S_SCAN;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_SCAN: begin
                priority if (stat.hit) begin
                    state_next = (stat.action == ACT_FIND) ? S_FINISH : S_SHIFT;
                end else if (stat.scan_end) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SHIFT: begin
                if (stat.shift_end) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands and pending result
    always_comb begin
        cmd              = '0;
        cmd.res_status   = ST_DONE;
        s_tready         = 1'b0;
        pend_status_next = pend_status_reg;
        pend_found_next  = pend_found_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            S_DECIDE: begin
                pend_found_next = 1'b0;
                unique case (stat.action)
                    ACT_INSERT: begin
                        if (stat.full) begin
                            pend_status_next = ST_FULL;
                        end else begin
                            cmd.insert       = 1'b1;
                            pend_status_next = ST_DONE;
                        end
                    end
                    ACT_REMOVE_FRONT: begin
                        if (stat.empty) begin
                            pend_status_next = ST_EMPTY;
                        end else begin
                            cmd.cnt_dec      = 1'b1;
                            pend_status_next = ST_DONE;
                        end
                    end
                    ACT_FIND, ACT_REMOVE_MATCH: begin
                        if (stat.empty) begin
                            pend_status_next = ST_EMPTY;
                        end else begin
                            cmd.scan_start = 1'b1;
                        end
                    end
                    default: pend_status_next = ST_DONE;
                endcase
            end
            S_SCAN: begin
                priority if (stat.hit) begin
                    pend_status_next = ST_DONE;
                    pend_found_next  = 1'b1;
                    cmd.shift_start  = (stat.action == ACT_REMOVE_MATCH);
                end else if (stat.scan_end) begin
                    pend_status_next = ST_NOTFOUND;
                    pend_found_next  = 1'b0;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (stat.shift_end) begin
                    cmd.cnt_dec = 1'b1;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FINISH: begin
                cmd.res_load   = slot_free;
                cmd.res_status = pend_status_reg;
                cmd.res_found  = pend_found_reg;
            end
            default: cmd = '0;
        endcase
    end

    // Hold the result until the transaction completes downstream
    assign out_valid_next = cmd.res_load || (out_valid_reg && !m_tready);
    assign m_tvalid       = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        pend_found_reg  <= pend_found_next;
    end

endmodule

`default_nettype wire

// File: rtl/bounded_list_store_core.sv
// Top level of the bounded list store: stream ports, controller and datapath.
//
// Keeps up to DEPTH signed 32-bit values, newest at the front, and answers each
// request with one result (status, found flag, count). One request is handled at a
// time. Find and remove-first-match search the list: the entries sit in a single
// memory with one read and one write port, and the search and the gap closing walk
// it one entry per cycle. A result waits in an output register, so the next request
// is taken while it is still unread. No clearing pass is needed after reset: entries
// at or above the count are never read.
`default_nettype none
`include "bounded_list_store_core_defines.svh"

module bounded_list_store_core #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // action [1:0], value [33:2], zero [39:34]
    input  wire logic [bls_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status [1:0], found [2], count [7:3]
    output logic [bls_pkg::M_TDATA_W-1:0]          m_tdata
);
    import bls_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    status_t            res_status;
    logic               res_found;
    logic [COUNT_W-1:0] res_count;

    bls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bls_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_action   (action_t'(s_tdata[ACTION_W-1:0])),
        .s_value    (s_tdata[ACTION_W +: VALUE_W]),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (res_status),
        .res_found  (res_found),
        .res_count  (res_count)
    );

    // Pack the result fields, status lowest
    assign m_tdata = {res_count, res_found, res_status};

    // Busy after each accepted transaction
    `BLS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_tvalid && s_tready, !s_tready, "accepted while busy")
    // A located value always reports done
    `BLS_ASSERT_IMPLY(a_found_done, aclk, aresetn,
        m_tvalid && m_tdata[2], m_tdata[1:0] == ST_DONE, "found without done status")
    // Full status only when the list really is full
    `BLS_ASSERT_IMPLY(a_full_status, aclk, aresetn,
        cmd.res_load && (cmd.res_status == ST_FULL), stat.full, "full status with free room")

endmodule

`default_nettype wire
